// ===== hdl/qtpi_pkg.sv =====
// qtpi_pkg: shared types and constants for the quadtree page indirection core
// no dependencies
package qtpi_pkg;

   localparam int unsigned LOD_SHIFT = 12;

   localparam logic [2:0] CMD_RESIDENT = 3'd0;
   localparam logic [2:0] CMD_EVICT    = 3'd1;
   localparam logic [2:0] CMD_REBUILD  = 3'd2;
   localparam logic [2:0] CMD_READ     = 3'd3;
   localparam logic [2:0] CMD_COMMIT   = 3'd4;

   // first page index of level l, for l in 0..8
   function automatic logic [15:0] level_base(input logic [3:0] l);
      logic [15:0] r;
      unique case (l)
         4'd0: r = 16'd0;
         4'd1: r = 16'd1;
         4'd2: r = 16'd5;
         4'd3: r = 16'd21;
         4'd4: r = 16'd85;
         4'd5: r = 16'd341;
         4'd6: r = 16'd1365;
         4'd7: r = 16'd5461;
         default: r = 16'd21845;
      endcase
      return r;
   endfunction

   // level of an absolute index, clamped to max_levels-1
   function automatic logic [2:0] level_of(input logic [14:0] idx, input logic [3:0] maxl);
      logic [2:0] l;
      l = 3'd0;
      for (int i = 1; i < 8; i++) begin
         if ({1'b0, idx} >= level_base(4'(i)) && 4'(i) < maxl) l = 3'(i);
      end
      return l;
   endfunction

   // first child of page p at level l
   function automatic logic [14:0] child0(input logic [14:0] p, input logic [2:0] l);
      logic [15:0] rel;
      logic [15:0] side;
      logic [15:0] c;
      side = 16'd1 << l;
      rel  = {1'b0, p} - level_base({1'b0, l});
      c    = ((rel >> l) << ({1'b0, l} + 4'd2)) + ((rel & (side - 16'd1)) << 1)
             + level_base({1'b0, l} + 4'd1);
      return c[14:0];
   endfunction

   function automatic logic [14:0] parent(input logic [14:0] p, input logic [2:0] l);
      logic [15:0] rel;
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] r;
      rel = {1'b0, p} - level_base({1'b0, l});
      x   = rel & ((16'd1 << l) - 16'd1);
      y   = rel >> l;
      r   = level_base({1'b0, l} - 4'd1) + ((y >> 1) << (l - 3'd1)) + (x >> 1);
      return r[14:0];
   endfunction

   typedef struct packed {
      logic        we;
      logic [14:0] addr;
      logic [15:0] entry;
      logic        flag;
      logic        wr_flag;
      logic        wr_entry;
   } mem_wr_type;

endpackage

// ===== hdl/qtpi_table.sv =====
// qtpi_table: entry and cached-flag memories, one read and one write port each
// depends on qtpi_pkg
module qtpi_table
   import qtpi_pkg::*;
#(
   parameter int unsigned DEPTH = 21845
) (
   input  logic        clock,
   input  logic [14:0] rd_addr,
   output logic [15:0] rd_entry,
   output logic        rd_flag,
   input  mem_wr_type  wr
);

   logic [15:0] entry_mem [DEPTH];
   logic        flag_mem  [DEPTH];

   always_ff @(posedge clock) begin
      if (wr.we && wr.wr_entry) entry_mem[wr.addr] <= wr.entry;
      if (wr.we && wr.wr_flag) flag_mem[wr.addr] <= wr.flag;
      rd_entry <= entry_mem[rd_addr];
      rd_flag  <= flag_mem[rd_addr];
   end

endmodule

// ===== hdl/quadtree_page_indirection_update_core.sv =====
// quadtree page indirection core: one item at a time over the table memories
// a read passes through S_FIN_RD and S_FIN before its answer is registered, and the next item is
//   taken only once the answer has left; a walk visits each popped page and pushes the children of
//   uncached pages it updates; rebuild copies the parent entry into each uncached page
// after reset the core sweeps the table to zero before accepting items.
// the walk stack and table memories have one read and one write port, with registered reads.
// depends on qtpi_pkg and qtpi_table
module quadtree_page_indirection_update_core
   import qtpi_pkg::*;
#(
   parameter int unsigned MAX_LEVELS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic [14:0] req_page_index,
   input  logic [11:0] req_phys_page,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_entry_value,
   output logic        rsp_is_cached,
   output logic [7:0]  rsp_dirty_levels,
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata
);

   localparam logic [3:0] MAXL = 4'(MAX_LEVELS);
   localparam logic [15:0] TOTAL = 16'(((32'd1 << (2 * MAX_LEVELS)) - 32'd1) / 32'd3);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_PREAD  = 4'd2;  // parent entry read issued
   localparam logic [3:0] S_PWAIT  = 4'd3;
   localparam logic [3:0] S_POP    = 4'd4;
   localparam logic [3:0] S_VISIT  = 4'd5;  // flag of popped page available
   localparam logic [3:0] S_RB_RD  = 4'd6;
   localparam logic [3:0] S_RB_PAR = 4'd7;
   localparam logic [3:0] S_RB_WR  = 4'd8;
   localparam logic [3:0] S_FIN_RD = 4'd9;
   localparam logic [3:0] S_FIN    = 4'd10;
   localparam logic [3:0] S_PUSH   = 4'd11;

   logic [3:0]  state_ff, state_in;
   logic [2:0]  cmd_ff, cmd_in;
   logic [14:0] idx_ff, idx_in;
   logic [15:0] bits_ff, bits_in;
   logic [3:0]  lvl_cfg_ff;
   logic [2:0]  last_ff, last_in;
   logic        valid_ff, valid_in;
   logic [7:0]  dirty_ff, dirty_in;
   logic [5:0]  sp_ff, sp_in;
   logic [14:0] cur_ff, cur_in;
   logic [2:0]  cl_ff, cl_in;
   logic [2:0]  nch_ff, nch_in;
   logic [14:0] c0_ff, c0_in;
   logic [15:0] ptr_ff, ptr_in;
   logic [2:0]  rbl_ff, rbl_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_entry_ff, rsp_entry_in;
   logic        rsp_flag_ff, rsp_flag_in;
   logic [7:0]  rsp_dirty_ff, rsp_dirty_in;

   logic [14:0] rd_addr;
   logic [15:0] rd_entry;
   logic        rd_flag;
   mem_wr_type  wr;

   logic [17:0] stack_mem [32];
   logic [17:0] stk_rd;
   logic        stk_we;
   logic [4:0]  stk_waddr;
   logic [17:0] stk_wdata;
   logic [4:0]  stk_raddr;

   logic [3:0]  eff_l;
   logic [2:0]  lod_req;
   logic [14:0] p_pop;
   logic [2:0]  l_pop;

   assign eff_l = (lvl_cfg_ff == 4'd0) ? 4'd1 : ((lvl_cfg_ff > MAXL) ? MAXL : lvl_cfg_ff);
   assign lod_req = level_of(req_page_index, MAXL);
   assign p_pop = stk_rd[14:0];
   assign l_pop = stk_rd[17:15];

   qtpi_table #(.DEPTH(int'(TOTAL))) u_table (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_entry(rd_entry),
      .rd_flag (rd_flag),
      .wr      (wr)
   );

   always_ff @(posedge clock) begin
      if (stk_we) stack_mem[stk_waddr] <= stk_wdata;
      stk_rd <= stack_mem[stk_raddr];
   end

   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; idx_in = idx_ff; bits_in = bits_ff;
      last_in = last_ff; valid_in = valid_ff; dirty_in = dirty_ff; sp_in = sp_ff;
      cur_in = cur_ff; cl_in = cl_ff; nch_in = nch_ff; c0_in = c0_ff; ptr_in = ptr_ff;
      rbl_in = rbl_ff; rsp_valid_in = rsp_valid_ff; rsp_entry_in = rsp_entry_ff;
      rsp_flag_in = rsp_flag_ff; rsp_dirty_in = rsp_dirty_ff;
      rd_addr = idx_ff; wr = '0; stk_we = 1'b0; stk_waddr = sp_ff[4:0];
      stk_wdata = '0; stk_raddr = sp_ff[4:0] - 5'd1;
      req_ready = 1'b0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            wr = '{we: 1'b1, addr: ptr_ff[14:0], entry: 16'd0, flag: 1'b0,
                   wr_flag: 1'b1, wr_entry: 1'b1};
            ptr_in = ptr_ff + 16'd1;
            if (ptr_ff == TOTAL - 16'd1) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = !rsp_valid_ff;
            if (req_valid && !rsp_valid_ff) begin
               cmd_in = req_cmd; idx_in = req_page_index;
               valid_in = {1'b0, req_page_index} < level_base(eff_l);
               sp_in = '0;
               if (req_cmd == CMD_RESIDENT && valid_in) begin
                  bits_in = {4'(lod_req), req_phys_page};
                  wr = '{we: 1'b1, addr: req_page_index, entry: bits_in, flag: 1'b1,
                         wr_flag: 1'b1, wr_entry: 1'b1};
                  dirty_in = dirty_ff | (8'd1 << lod_req);
                  last_in = 3'(eff_l - 4'd1);
                  if ({1'b0, lod_req} + 4'd1 < eff_l) begin
                     c0_in = child0(req_page_index, lod_req);
                     cl_in = lod_req + 3'd1; nch_in = 3'd0; state_in = S_PUSH;
                  end else state_in = S_FIN_RD;
               end else if (req_cmd == CMD_EVICT && valid_in) begin
                  wr = '{we: 1'b1, addr: req_page_index, entry: 16'd0, flag: 1'b0,
                         wr_flag: 1'b1, wr_entry: 1'b0};
                  last_in = (4'(lod_req) + eff_l - 4'd2 > eff_l - 4'd1) ?
                            3'(eff_l - 4'd1) : 3'(4'(lod_req) + eff_l - 4'd2);
                  cl_in = lod_req;
                  if (eff_l < 4'd2) state_in = S_FIN_RD;
                  else if (lod_req == 3'd0) begin
                     bits_in = '0; stk_we = 1'b1; stk_waddr = 5'd0;
                     stk_wdata = {lod_req, req_page_index};
                     sp_in = 6'd1; state_in = S_POP;
                  end else begin
                     rd_addr = parent(req_page_index, lod_req);
                     state_in = S_PREAD;
                  end
               end else if (req_cmd == CMD_REBUILD) begin
                  rd_addr = '0; ptr_in = '0; rbl_in = '0; state_in = S_RB_RD;
               end else state_in = S_FIN_RD;
            end
         end
         S_PREAD: begin
            bits_in = rd_entry; stk_we = 1'b1; stk_wdata = {cl_ff, idx_ff};
            sp_in = sp_ff + 6'd1; state_in = S_POP;
         end
         S_PUSH: begin
            // push children c0, c0+1, c0+side, c0+side+1, where side is 1 << cl
            stk_we = 1'b1;
            stk_wdata = {cl_ff, c0_ff + ((nch_ff[1]) ? (15'(1) << (cl_ff)) : 15'd0)
                         + 15'(nch_ff[0])};
            sp_in = sp_ff + 6'd1;
            if (nch_ff == 3'd3) state_in = S_POP;
            else nch_in = nch_ff + 3'd1;
         end
         S_POP: begin
            if (sp_ff == 6'd0) state_in = S_FIN_RD;
            else begin
               sp_in = sp_ff - 6'd1; state_in = S_PWAIT;
            end
         end
         S_PWAIT: begin
            rd_addr = p_pop; cur_in = p_pop; cl_in = l_pop;
            if ({1'b0, p_pop} >= TOTAL) state_in = S_POP;
            else state_in = S_VISIT;
         end
         S_VISIT: begin
            if (rd_flag) state_in = S_POP;
            else begin
               wr = '{we: 1'b1, addr: cur_ff, entry: bits_ff, flag: 1'b0,
                      wr_flag: 1'b0, wr_entry: 1'b1};
               dirty_in = dirty_ff | (8'd1 << cl_ff);
               if ({1'b0, cl_ff} + 4'd1 <= {1'b0, last_ff} && sp_ff + 6'd4 <= 6'd32) begin
                  c0_in = child0(cur_ff, cl_ff); cl_in = cl_ff + 3'd1;
                  nch_in = 3'd0; state_in = S_PUSH;
               end else state_in = S_POP;
            end
         end
         S_RB_RD: begin
            // flag and entry of ptr now valid
            if (rbl_ff == 3'd0) begin
               if (!rd_flag) wr = '{we: 1'b1, addr: '0, entry: 16'd0, flag: 1'b0,
                                    wr_flag: 1'b0, wr_entry: 1'b1};
               state_in = S_RB_WR;
            end else if (rd_flag) state_in = S_RB_WR;
            else begin
               rd_addr = parent(ptr_ff[14:0], rbl_ff); state_in = S_RB_PAR;
            end
         end
         S_RB_PAR: begin
            wr = '{we: 1'b1, addr: ptr_ff[14:0], entry: rd_entry, flag: 1'b0,
                   wr_flag: 1'b0, wr_entry: 1'b1};
            state_in = S_RB_WR;
         end
         S_RB_WR: begin
            ptr_in = ptr_ff + 16'd1;
            if (ptr_ff + 16'd1 >= level_base(eff_l)) begin
               rd_addr = idx_ff; state_in = S_FIN;
            end else begin
               if (ptr_ff + 16'd1 >= level_base({1'b0, rbl_ff} + 4'd1)) rbl_in = rbl_ff + 3'd1;
               rd_addr = ptr_in[14:0]; state_in = S_RB_RD;
            end
         end
         S_FIN_RD: begin
            rd_addr = idx_ff; state_in = S_FIN;
         end
         S_FIN: begin
            rsp_valid_in = 1'b1;
            rsp_entry_in = valid_ff ? rd_entry : 16'd0;
            rsp_flag_in = valid_ff ? rd_flag : 1'b0;
            rsp_dirty_in = dirty_ff;
            if (cmd_ff == CMD_COMMIT) dirty_in = '0;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; ptr_ff <= '0; dirty_ff <= '0; rsp_valid_ff <= 1'b0;
         lvl_cfg_ff <= 4'd8; sp_ff <= '0;
      end else begin
         state_ff <= state_in; ptr_ff <= ptr_in; dirty_ff <= dirty_in;
         rsp_valid_ff <= rsp_valid_in; sp_ff <= sp_in;
         if (csr_we) lvl_cfg_ff <= csr_wdata;
      end
      cmd_ff <= cmd_in; idx_ff <= idx_in; bits_ff <= bits_in; last_ff <= last_in;
      valid_ff <= valid_in; cur_ff <= cur_in; cl_ff <= cl_in; nch_ff <= nch_in;
      c0_ff <= c0_in; rbl_ff <= rbl_in; rsp_entry_ff <= rsp_entry_in;
      rsp_flag_ff <= rsp_flag_in; rsp_dirty_ff <= rsp_dirty_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_entry_value = rsp_entry_ff;
   assign rsp_is_cached = rsp_flag_ff;
   assign rsp_dirty_levels = rsp_dirty_ff;

`ifndef SYNTHESIS
   a_sp_bound: assert property (@(posedge clock) disable iff (reset) sp_ff <= 6'd32)
      else $error("walk stack overflow");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == S_IDLE && !rsp_valid_ff)
      else $error("ready outside idle");
   a_commit_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIN && cmd_ff == CMD_COMMIT |=> dirty_ff == 8'd0)
      else $error("commit did not clear dirty levels");
`endif

endmodule
